FILE: hdl/rsfb_pkg.sv
// Shared types and constants for the RS-485 frame buffer.
// Used by the front end, back end and top level; no dependencies.
package rsfb_pkg;

  localparam logic [3:0] OP_RX_BYTE   = 4'd0;
  localparam logic [3:0] OP_TICK      = 4'd1;
  localparam logic [3:0] OP_TX_CLEAR  = 4'd2;
  localparam logic [3:0] OP_TX_APPEND = 4'd3;
  localparam logic [3:0] OP_TX_LEN    = 4'd4;
  localparam logic [3:0] OP_TX_START  = 4'd5;
  localparam logic [3:0] OP_TX_EMPTY  = 4'd6;
  localparam logic [3:0] OP_TX_DONE   = 4'd7;
  localparam logic [3:0] OP_RX_READ   = 4'd8;
  localparam logic [3:0] OP_NOP       = 4'd9;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;
  localparam int RES_CW    = $clog2(RES_DEPTH + 1);

  localparam logic CFG_IDX_TIMEOUT = 1'b0;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] read_index;
    logic [8:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic       line_byte_valid;
    logic [7:0] line_byte;
    logic       driver_enable;
    logic       frame_ready;
    logic [7:0] rx_count;
    logic [7:0] read_byte;
  } out_item_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data_byte;
    logic [7:0] read_index;
    logic       rd_ok;
    logic [8:0] length;
  } cmd_t;

endpackage

FILE: hdl/rsfb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module rsfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/rsfb_fifo.sv
// Small flop-based FIFO with occupancy count.
// No dependencies; DEPTH must be a power of two.
module rsfb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full,
  output logic                       empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];
  assign count   = count_r;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hdl/rsfb_front.sv
// Front end: accepts input items, classifies opcodes, range-checks fields.
// Depends on rsfb_pkg and rsfb_fifo (command queue).
module rsfb_front #(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rsfb_pkg::in_item_t in_item,
  output logic              full,
  input  logic              cmd_pop,
  output logic              cmd_valid,
  output rsfb_pkg::cmd_t    cmd
);
  import rsfb_pkg::*;

  cmd_t                         dec;
  logic [$bits(cmd_t)-1:0]      cmd_bits;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
  logic                         cmd_empty;

  always_comb begin
    dec.data_byte  = in_item.data_byte;
    dec.read_index = in_item.read_index;
    dec.rd_ok      = (32'(in_item.read_index) < RX_DEPTH);
    dec.length     = (32'(in_item.frame_length) > TX_DEPTH) ? 9'(TX_DEPTH)
                                                            : in_item.frame_length;
    case (in_item.opcode)
      OP_RX_BYTE, OP_TICK, OP_TX_CLEAR, OP_TX_APPEND, OP_TX_LEN,
      OP_TX_START, OP_TX_EMPTY, OP_TX_DONE, OP_RX_READ: begin
        dec.kind = in_item.opcode;
      end
      default: begin
        dec.kind = OP_NOP;
      end
    endcase
  end

  rsfb_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (dec),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .count (cmd_count),
    .full  (full),
    .empty (cmd_empty)
  );

  assign cmd       = cmd_t'(cmd_bits);
  assign cmd_valid = !cmd_empty && (cmd_count != '0);

endmodule

FILE: hdl/rsfb_back.sv
// Back end: receive/transmit state, frame stores, result assembly.
// Depends on rsfb_pkg and rsfb_ram.
module rsfb_back #(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [15:0]                reload,
  input  logic                       cmd_valid,
  input  rsfb_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  input  logic [rsfb_pkg::RES_CW-1:0] res_count,
  output logic                       res_push,
  output rsfb_pkg::out_item_t        res_item
);
  import rsfb_pkg::*;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_LW = $clog2(TX_DEPTH + 1);

  logic [RX_AW-1:0] rx_fill_r, rx_fill_nxt, rx_base;
  logic [15:0]      timer_r, timer_nxt;
  logic             ready_r, ready_nxt;
  logic [TX_LW-1:0] tx_len_r, tx_len_nxt;
  logic [TX_LW-1:0] tx_pos_r, tx_pos_nxt, tx_pos_inc;
  logic             earm_r, earm_nxt;
  logic             carm_r, carm_nxt;
  logic             drive_r, drive_nxt;

  logic             s1_valid_r;
  logic             s1_lvalid_r, s1_lvalid_nxt;
  logic             s1_rsel_r, s1_rsel_nxt;

  logic             s1_drive_r, s1_ready_r;
  logic [7:0]       s1_count_r;

  logic             rx_we, tx_we;
  logic [RX_AW-1:0] rx_addr;
  logic [TX_AW-1:0] tx_addr;
  logic [7:0]       rx_rdata, tx_rdata;
  logic [RX_AW+7:0] ridx_ext, cnt_ext;
  logic [TX_LW+8:0] len_ext;

  assign cmd_pop    = cmd_valid &&
                      ((32'(res_count) + 32'(s1_valid_r)) < RES_DEPTH);
  assign ridx_ext   = {{RX_AW{1'b0}}, cmd.read_index};
  assign len_ext    = {{TX_LW{1'b0}}, cmd.length};
  assign rx_base    = (timer_r == '0) ? '0 : rx_fill_r;
  assign tx_pos_inc = tx_pos_r + 1'b1;
  assign cnt_ext    = {8'd0, rx_fill_nxt};

  always_comb begin
    rx_fill_nxt   = rx_fill_r;
    timer_nxt     = timer_r;
    ready_nxt     = ready_r;
    tx_len_nxt    = tx_len_r;
    tx_pos_nxt    = tx_pos_r;
    earm_nxt      = earm_r;
    carm_nxt      = carm_r;
    drive_nxt     = drive_r;
    rx_we         = 1'b0;
    tx_we         = 1'b0;
    rx_addr       = rx_base;
    tx_addr       = tx_pos_r[TX_AW-1:0];
    s1_lvalid_nxt = 1'b0;
    s1_rsel_nxt   = 1'b0;
    if (cmd_pop) begin
      case (cmd.kind)
        OP_RX_BYTE: begin
          if (timer_r == '0) begin
            ready_nxt = 1'b0;
          end
          rx_we       = 1'b1;
          rx_fill_nxt = (rx_base == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_base + 1'b1;
          timer_nxt   = reload;
        end
        OP_TICK: begin
          if (timer_r != '0) begin
            timer_nxt = timer_r - 1'b1;
            if (timer_r == 16'd1) begin
              ready_nxt = 1'b1;
            end
          end
        end
        OP_TX_CLEAR: begin
          tx_len_nxt = '0;
          tx_pos_nxt = '0;
        end
        OP_TX_APPEND: begin
          tx_addr = tx_len_r[TX_AW-1:0];
          if (tx_len_r != TX_LW'(TX_DEPTH)) begin
            tx_we      = 1'b1;
            tx_len_nxt = tx_len_r + 1'b1;
          end
        end
        OP_TX_LEN: begin
          tx_len_nxt = len_ext[TX_LW-1:0];
        end
        OP_TX_START: begin
          if (tx_len_r != '0) begin
            tx_pos_nxt = '0;
            drive_nxt  = 1'b1;
            earm_nxt   = 1'b1;
            carm_nxt   = 1'b0;
          end
        end
        OP_TX_EMPTY: begin
          if (earm_r && (tx_pos_r < tx_len_r)) begin
            s1_lvalid_nxt = 1'b1;
            tx_pos_nxt    = tx_pos_inc;
            if (tx_pos_inc == tx_len_r) begin
              earm_nxt = 1'b0;
              carm_nxt = 1'b1;
            end
          end
        end
        OP_TX_DONE: begin
          if (carm_r) begin
            drive_nxt  = 1'b0;
            carm_nxt   = 1'b0;
            tx_len_nxt = '0;
            tx_pos_nxt = '0;
          end
        end
        OP_RX_READ: begin
          rx_addr     = ridx_ext[RX_AW-1:0];
          s1_rsel_nxt = cmd.rd_ok;
        end
        default: begin
        end
      endcase
    end
  end

  rsfb_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .addr  (rx_addr),
    .wdata (cmd.data_byte),
    .rdata (rx_rdata)
  );

  rsfb_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .addr  (tx_addr),
    .wdata (cmd.data_byte),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_fill_r  <= '0;
      timer_r    <= '0;
      ready_r    <= 1'b0;
      tx_len_r   <= '0;
      tx_pos_r   <= '0;
      earm_r     <= 1'b0;
      carm_r     <= 1'b0;
      drive_r    <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      rx_fill_r  <= rx_fill_nxt;
      timer_r    <= timer_nxt;
      ready_r    <= ready_nxt;
      tx_len_r   <= tx_len_nxt;
      tx_pos_r   <= tx_pos_nxt;
      earm_r     <= earm_nxt;
      carm_r     <= carm_nxt;
      drive_r    <= drive_nxt;
      s1_valid_r <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    s1_lvalid_r <= s1_lvalid_nxt;
    s1_rsel_r   <= s1_rsel_nxt;
    s1_drive_r  <= drive_nxt;
    s1_ready_r  <= ready_nxt;
    s1_count_r  <= cnt_ext[7:0];
  end

  assign res_push = s1_valid_r;

  always_comb begin
    res_item.line_byte_valid = s1_lvalid_r;
    res_item.line_byte       = s1_lvalid_r ? tx_rdata : 8'd0;
    res_item.driver_enable   = s1_drive_r;
    res_item.frame_ready     = s1_ready_r;
    res_item.rx_count        = s1_count_r;
    res_item.read_byte       = s1_rsel_r ? rx_rdata : 8'd0;
  end

  // invariants
  a_arm_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({earm_r, carm_r}))
    else $error("empty and complete both armed");

  a_arm_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (earm_r || carm_r) |-> drive_r)
    else $error("transmit armed with driver off");

  a_ready_timer: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (timer_r == '0))
    else $error("frame ready while silence timer running");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(res_count) + 32'(s1_valid_r)) <= RES_DEPTH)
    else $error("result queue overcommitted");

endmodule

FILE: hdl/rs485_frame_buffer_with_silence_timeout.sv
// Top level of the RS-485 frame buffer: config port, front/back, result queue.
// Depends on rsfb_pkg, rsfb_front, rsfb_back and rsfb_fifo.
//
// Takes one item per clock on the push/full side while full is low and delivers
// one result item per item on the empty/pop side, in order. An accepted item
// passes through the command queue and the store-access register stage into the
// result queue, from which it can be popped. Throughput is one item per cycle
// while the result queue has room, set by the single port of each frame store:
// every item makes at most one store access. A two-entry command queue and a
// four-entry result queue let the input and output sides stall independently.
// The silence timeout register sits at byte address 0 of the config port; its
// tick reload (timeout * 10, saturated to 16 bits) is computed on each write.
module rs485_frame_buffer_with_silence_timeout #(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  rsfb_pkg::in_item_t   in_item,
  output logic                 empty,
  input  logic                 pop,
  output rsfb_pkg::out_item_t  out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rsfb_pkg::*;

  logic [12:0]                timeout_r, timeout_nxt;
  logic [15:0]                reload_r, reload_nxt;
  logic [16:0]                prod;
  logic                       cfg_wr;
  logic                       cmd_valid, cmd_pop;
  cmd_t                       cmd;
  logic                       res_push;
  out_item_t                  res_item;
  logic [RES_CW-1:0]          res_count;
  logic                       res_full;
  logic [$bits(out_item_t)-1:0] res_bits;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_TIMEOUT);
  assign prdata = (paddr[2] == CFG_IDX_TIMEOUT) ? {19'd0, timeout_r} : 32'd0;
  assign prod   = {1'b0, pwdata[12:0], 3'b000} + {3'b000, pwdata[12:0], 1'b0};

  always_comb begin
    timeout_nxt = timeout_r;
    reload_nxt  = reload_r;
    if (cfg_wr) begin
      timeout_nxt = pwdata[12:0];
      reload_nxt  = prod[16] ? 16'hFFFF : prod[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= '0;
      reload_r  <= '0;
    end else begin
      timeout_r <= timeout_nxt;
      reload_r  <= reload_nxt;
    end
  end

  rsfb_front #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  rsfb_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .reload    (reload_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  rsfb_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .pop   (pop),
    .rdata (res_bits),
    .count (res_count),
    .full  (res_full),
    .empty (empty)
  );

  assign out_item = res_full ? out_item_t'(res_bits) : out_item_t'(res_bits);

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for rs485_frame_buffer_with_silence_timeout: directed table, then random
// framed traffic over several silence timeouts, checked against an in-bench frame engine.
// Depends on rsfb_pkg and the block's RTL.
module tb_top;
  import rsfb_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int TICKS_PER_UNIT = 10;
  localparam int TIMER_MAX = 65535;
  localparam logic [2:0] TIMEOUT_ADDR = 3'(4 * CFG_IDX_TIMEOUT);
  localparam int PHASE_ITEMS = 237;

  logic clk = 1'b0;
  logic rst_n;
  logic push, full, empty, pop;
  in_item_t in_item;
  out_item_t out_item;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  rs485_frame_buffer_with_silence_timeout uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // frame engine state
  logic [7:0] rx_mem [STORE_DEPTH];
  logic [7:0] tx_mem [STORE_DEPTH];
  bit rx_seen [STORE_DEPTH];
  bit tx_seen [STORE_DEPTH];
  int rx_seen_idx[$];
  int frame_cnt, quiet_cnt, tx_count, tx_idx, timeout_reg;
  bit ready_q, empty_arm, done_arm, drv_q;

  out_item_t result_q[$];
  in_item_t stim_q[$];
  int err_cnt = 0;
  int wraps_left = 2;
  int fills_left = 2;

  typedef struct {
    in_item_t it;
    int reps;
    bit typed;
    out_item_t want;
  } dir_row_t;
  dir_row_t dir_tab[$];

  function automatic int silence_reload();
    int reload;
    reload = timeout_reg * TICKS_PER_UNIT;
    return (reload > TIMER_MAX) ? TIMER_MAX : reload;
  endfunction

  function automatic out_item_t engine_step(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.opcode)
      OP_RX_BYTE: begin
        if (quiet_cnt == 0) begin
          ready_q = 1'b0;
          frame_cnt = 0;
        end
        rx_mem[frame_cnt] = it.data_byte;
        if (!rx_seen[frame_cnt]) begin
          rx_seen[frame_cnt] = 1'b1;
          rx_seen_idx.push_back(frame_cnt);
        end
        frame_cnt = (frame_cnt + 1) % STORE_DEPTH;
        quiet_cnt = silence_reload();
      end
      OP_TICK: begin
        if (quiet_cnt != 0) begin
          quiet_cnt--;
          if (quiet_cnt == 0) ready_q = 1'b1;
        end
      end
      OP_TX_CLEAR: begin
        tx_count = 0;
        tx_idx = 0;
      end
      OP_TX_APPEND: begin
        if (tx_count < STORE_DEPTH) begin
          tx_mem[tx_count] = it.data_byte;
          tx_seen[tx_count] = 1'b1;
          tx_count++;
        end
      end
      OP_TX_LEN: tx_count = (it.frame_length > STORE_DEPTH) ? STORE_DEPTH : it.frame_length;
      OP_TX_START: begin
        if (tx_count != 0) begin
          tx_idx = 0;
          drv_q = 1'b1;
          empty_arm = 1'b1;
          done_arm = 1'b0;
        end
      end
      OP_TX_EMPTY: begin
        if (empty_arm && tx_idx < tx_count) begin
          r.line_byte_valid = 1'b1;
          r.line_byte = tx_mem[tx_idx];
          tx_idx++;
          if (tx_idx == tx_count) begin
            empty_arm = 1'b0;
            done_arm = 1'b1;
          end
        end
      end
      OP_TX_DONE: begin
        if (done_arm) begin
          drv_q = 1'b0;
          done_arm = 1'b0;
          tx_count = 0;
          tx_idx = 0;
        end
      end
      OP_RX_READ: r.read_byte = rx_mem[it.read_index];
      default: ;
    endcase
    r.driver_enable = drv_q;
    r.frame_ready = ready_q;
    r.rx_count = 8'(frame_cnt);
    return r;
  endfunction

  // random fields; reads only hit written rx entries, lengths only cover written tx entries
  function automatic in_item_t any_item(logic [3:0] op);
    in_item_t it;
    int n;
    n = 0;
    it.opcode = op;
    it.data_byte = 8'($urandom_range(0, 255));
    it.read_index = 8'($urandom_range(0, 255));
    it.frame_length = 9'($urandom_range(0, 511));
    if (op == OP_RX_READ) begin
      if (rx_seen_idx.size() == 0) it.opcode = OP_TICK;
      else it.read_index = 8'(rx_seen_idx[$urandom_range(0, rx_seen_idx.size() - 1)]);
    end
    if (op == OP_TX_LEN) begin
      while (n < STORE_DEPTH && tx_seen[n]) n++;
      if (n < STORE_DEPTH) it.frame_length = 9'($urandom_range(0, n));
    end
    return it;
  endfunction

  function automatic void row(in_item_t it, int reps, bit typed, out_item_t want);
    dir_row_t d;
    d.it = it;
    d.reps = reps;
    d.typed = typed;
    d.want = want;
    dir_tab.push_back(d);
  endfunction

  task automatic gen_sequence();
    int pick, n, k, reload;
    bit wrap_frame;
    reload = silence_reload();
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      wrap_frame = (wraps_left > 0 && reload != 0 && $urandom_range(0, 9) == 0);
      if (wrap_frame) wraps_left--;
      n = wrap_frame ? $urandom_range(257, 262) : $urandom_range(1, 16);
      repeat (n) begin
        stim_q.push_back(any_item(OP_RX_BYTE));
        repeat ($urandom_range(0, wrap_frame ? 1 : 4)) stim_q.push_back(any_item(OP_TICK));
      end
      if (reload <= 100) begin
        k = reload + $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0 && k > 0) k--;
      end else begin
        k = $urandom_range(0, 5);
      end
      repeat (k) stim_q.push_back(any_item(OP_TICK));
      repeat ($urandom_range(1, 3)) stim_q.push_back(any_item(OP_RX_READ));
    end else if (pick < 8) begin
      if ($urandom_range(0, 1)) stim_q.push_back(any_item(OP_TX_CLEAR));
      if (fills_left > 0 && $urandom_range(0, 19) == 0) begin
        fills_left--;
        stim_q.push_back(any_item(OP_TX_CLEAR));
        repeat (STORE_DEPTH + 2) stim_q.push_back(any_item(OP_TX_APPEND));
      end else begin
        k = $urandom_range(1, 12);
        repeat (k) stim_q.push_back(any_item(OP_TX_APPEND));
        if ($urandom_range(0, 3) == 0) stim_q.push_back(any_item(OP_TX_LEN));
        stim_q.push_back(any_item(OP_TX_START));
        repeat (k + $urandom_range(0, 2)) begin
          stim_q.push_back(any_item(OP_TX_EMPTY));
          if ($urandom_range(0, 15) == 0)
            stim_q.push_back(any_item($urandom_range(0, 1) ? OP_TX_START : OP_RX_BYTE));
        end
        if ($urandom_range(0, 7) != 0) stim_q.push_back(any_item(OP_TX_DONE));
      end
    end else begin
      repeat ($urandom_range(1, 6)) stim_q.push_back(any_item(4'($urandom_range(0, 15))));
    end
  endtask

  int tx_mode_left = 0;
  bit tx_no_idle;

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t pred;
    if (tx_mode_left == 0) begin
      tx_no_idle = ($urandom_range(0, 2) == 0);
      tx_mode_left = $urandom_range(20, 60);
    end
    tx_mode_left--;
    repeat (tx_no_idle ? 0 : $urandom_range(0, 12)) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full !== 1'b0);
    pred = engine_step(it);
    result_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(int v);
    logic [31:0] rd;
    drain();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_ADDR;
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    timeout_reg = v & 'h1FFF;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(timeout_reg)) begin
      $display("%0t: silence timeout readback expected %0d got %0d", $time, timeout_reg, rd);
      err_cnt++;
    end
  endtask

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      err_cnt++;
    end
  endtask

  // result side
  initial begin
    int rx_mode_left, hold_at, taken;
    bit rx_no_idle;
    out_item_t got, want;
    rx_mode_left = 0;
    hold_at = 400;
    taken = 0;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken >= hold_at) begin
        hold_at += 900;
        repeat (200) @(negedge clk) pop <= 1'b0;
      end
      if (rx_mode_left == 0) begin
        rx_no_idle = ($urandom_range(0, 2) == 0);
        rx_mode_left = $urandom_range(20, 60);
      end
      rx_mode_left--;
      repeat (rx_no_idle ? 0 : $urandom_range(0, 12)) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      got = out_item;
      taken++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        check_field("line_byte_valid", want.line_byte_valid, got.line_byte_valid);
        check_field("line_byte", want.line_byte, got.line_byte);
        check_field("driver_enable", want.driver_enable, got.driver_enable);
        check_field("frame_ready", want.frame_ready, got.frame_ready);
        check_field("rx_count", want.rx_count, got.rx_count);
        check_field("read_byte", want.read_byte, got.read_byte);
      end
    end
  end

  // item side
  initial begin
    int phase_timeout[8];
    int issued, total;
    phase_timeout = '{3, 0, 6553, 1, 8191, 2, 1, 0};
    phase_timeout[7] = $urandom_range(1, 8);
    total = 0;
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // timeout at reset value 0: every byte opens a new frame
    row({OP_RX_BYTE, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_RX_BYTE, 8'hFF, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_TICK, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_RX_READ, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'hFF});
    // start, empty and complete with nothing armed
    row({OP_TX_START, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_TX_EMPTY, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_TX_DONE, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_TX_APPEND, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_TX_APPEND, 8'hFF, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_TX_START, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b1, 1'b0, 8'd1, 8'h00});
    row({OP_TX_EMPTY, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b1, 8'h00, 1'b1, 1'b0, 8'd1, 8'h00});
    // restart mid-frame
    row({OP_TX_START, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b1, 1'b0, 8'd1, 8'h00});
    row({OP_TX_EMPTY, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b1, 8'h00, 1'b1, 1'b0, 8'd1, 8'h00});
    row({OP_TX_EMPTY, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b1, 8'hFF, 1'b1, 1'b0, 8'd1, 8'h00});
    row({OP_TX_EMPTY, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b1, 1'b0, 8'd1, 8'h00});
    row({OP_TX_DONE, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    // oversize length saturates, then cleared before anything reads it
    row({OP_TX_LEN, 8'h00, 8'h00, 9'h1FF}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_TX_CLEAR, 8'h00, 8'h00, 9'd0}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_NOP + 4'd6, 8'hFF, 8'hFF, 9'h1FF}, 1, 1, {1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00});
    row({OP_NOP, 8'h5A, 8'hA5, 9'h0AA}, 1, 0, '0);
    row({OP_TX_LEN, 8'h00, 8'h00, 9'd2}, 1, 0, '0);
    row({OP_TX_START, 8'h00, 8'h00, 9'd0}, 1, 0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      repeat (dir_tab[i].reps) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

    // phases share one item budget so long frames do not inflate the total
    foreach (phase_timeout[p]) begin
      cfg_write(phase_timeout[p]);
      issued = 0;
      while (issued < PHASE_ITEMS / 4 || total < (p + 1) * PHASE_ITEMS ||
             stim_q.size() != 0) begin
        if (stim_q.size() == 0) gen_sequence();
        send_item(stim_q.pop_front(), 1'b0, '0);
        issued++;
        total++;
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
